@@ hw/rtl/acs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// acs_pkg
// Shared widths, codes and control structures of the Allen-Cahn stencil
// right-hand-side block.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int unsigned MaxNodes = 1024;
  localparam int unsigned IdxW     = $clog2(MaxNodes);
  localparam int unsigned CountW   = IdxW + 1;

  localparam int unsigned SampleW  = 18;  // Q3.14
  localparam int unsigned GainW    = 32;  // unsigned Q16.16
  localparam int unsigned RateW    = 32;  // Q17.14
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned LapW     = SampleW + 2;
  localparam int unsigned DiffW    = LapW + GainW + 1;
  localparam int unsigned SqW      = 2 * SampleW;
  localparam int unsigned CubeW    = 3 * SampleW;
  localparam int unsigned AccW     = CubeW + 2;
  localparam int unsigned CubeDrop = 12;  // Q.42 to Q.30
  localparam int unsigned FracDrop = 16;  // Q.30 to Q.14
  localparam int unsigned RndW     = AccW - FracDrop;

  typedef enum logic [CfgIdxW-1:0] {
    RegGain      = 1'b0,
    RegNodeCount = 1'b1
  } cfg_reg_e;

  // Which of the two possible results of one beat is being worked on.
  typedef enum logic {
    JobInner = 1'b0,
    JobFinal = 1'b1
  } job_e;

  typedef struct packed {
    logic accept;
    job_e sel;
    logic mul1_en;
    logic mul2_en;
    logic sum_en;
    logic rnd_en;
  } acs_cmd_t;

  typedef struct packed {
    logic has_inner;
    logic has_final;
  } acs_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/acs_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// acs_ctrl
// Sequencer: takes one input beat, then steps the shared datapath through
// up to two results and holds each one until the receiver takes it.
// ----------------------------------------------------------------------------
module acs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  acs_pkg::acs_status_t status_i,
  output acs_pkg::acs_cmd_t   cmd_o
);
  import acs_pkg::*;

  typedef enum logic [6:0] {
    StIdle     = 7'b0000001,
    StDispatch = 7'b0000010,
    StMul1     = 7'b0000100,
    StMul2     = 7'b0001000,
    StSum      = 7'b0010000,
    StRnd      = 7'b0100000,
    StOut      = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  job_e   sel_q, sel_d;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.sel = sel_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StDispatch;
        end
      end
      StDispatch: begin
        priority if (status_i.has_inner) begin
          sel_d   = JobInner;
          state_d = StMul1;
        end else if (status_i.has_final) begin
          sel_d   = JobFinal;
          state_d = StMul1;
        end else begin
          state_d = StIdle;
        end
      end
      StMul1: begin
        cmd_o.mul1_en = 1'b1;
        state_d       = StMul2;
      end
      StMul2: begin
        cmd_o.mul2_en = 1'b1;
        state_d       = StSum;
      end
      StSum: begin
        cmd_o.sum_en = 1'b1;
        state_d      = StRnd;
      end
      StRnd: begin
        cmd_o.rnd_en = 1'b1;
        state_d      = StOut;
      end
      StOut: begin
        if (out_ready_i) begin
          if (sel_q == JobInner && status_i.has_final) begin
            sel_d   = JobFinal;
            state_d = StMul1;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sel_q   <= JobInner;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

endmodule
`default_nettype wire

@@ hw/rtl/acs_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// acs_datapath
// Configuration registers, two-sample delay line, node counter and the
// shared Laplacian / cubic arithmetic with rounding and saturation.
// ----------------------------------------------------------------------------
module acs_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [acs_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [acs_pkg::CfgDataW-1:0]         cfg_data_i,
  input  logic signed [acs_pkg::SampleW-1:0]   sample_i,
  input  logic                                 compute_flag_i,
  input  acs_pkg::acs_cmd_t                    cmd_i,
  output acs_pkg::acs_status_t                 status_o,
  output logic signed [acs_pkg::RateW-1:0]     rate_o,
  output logic [acs_pkg::IdxW-1:0]             node_index_o,
  output logic                                 run_last_o,
  output logic                                 vector_last_o
);
  import acs_pkg::*;

  // Configuration.
  logic [GainW-1:0]  gain_q;
  logic [CountW-1:0] ncount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= '0;
      ncount_q <= CountW'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegGain:      gain_q   <= cfg_data_i[GainW-1:0];
        RegNodeCount: ncount_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Index of the final node, with the node count clamped to its legal range.
  logic [IdxW-1:0] last_idx;
  always_comb begin
    if (ncount_q < CountW'(2)) begin
      last_idx = IdxW'(1);
    end else if (ncount_q > CountW'(MaxNodes)) begin
      last_idx = IdxW'(MaxNodes - 1);
    end else begin
      last_idx = IdxW'(ncount_q - CountW'(1));
    end
  end

  // Delay line and node counter.
  logic signed [SampleW-1:0] prev_q, older_q;
  logic                      pflag_q;
  logic [IdxW-1:0]           cnt_q;
  logic                      is_last;

  assign is_last = (cnt_q >= last_idx);

  // Operands of the beat in progress.
  logic signed [SampleW-1:0] j_left_q, j_mid_q, j_new_q;
  logic [IdxW-1:0]           j_idx_q;
  logic                      has_inner_q, has_final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      older_q     <= '0;
      pflag_q     <= 1'b0;
      cnt_q       <= '0;
      has_inner_q <= 1'b0;
      has_final_q <= 1'b0;
    end else if (cmd_i.accept) begin
      prev_q      <= sample_i;
      older_q     <= prev_q;
      pflag_q     <= compute_flag_i;
      cnt_q       <= is_last ? '0 : cnt_q + IdxW'(1);
      has_inner_q <= (cnt_q != '0) && pflag_q;
      has_final_q <= is_last && compute_flag_i;
    end
  end

  // The first node mirrors its right neighbour, the incoming sample, as its left neighbour.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      j_left_q <= (cnt_q == IdxW'(1)) ? sample_i : older_q;
      j_mid_q  <= prev_q;
      j_new_q  <= sample_i;
      j_idx_q  <= cnt_q;
    end
  end

  assign status_o.has_inner = has_inner_q;
  assign status_o.has_final = has_final_q;

  // Stencil operands of the selected result.
  logic signed [SampleW-1:0] op_l, op_c, op_r;
  logic [IdxW-1:0]           op_idx;

  always_comb begin
    unique case (cmd_i.sel)
      JobInner: begin
        op_l   = j_left_q;
        op_c   = j_mid_q;
        op_r   = j_new_q;
        op_idx = j_idx_q - IdxW'(1);
      end
      JobFinal: begin
        op_l   = j_mid_q;
        op_c   = j_new_q;
        op_r   = j_mid_q;
        op_idx = j_idx_q;
      end
      default: begin
        op_l   = j_left_q;
        op_c   = j_mid_q;
        op_r   = j_new_q;
        op_idx = j_idx_q;
      end
    endcase
  end

  // First multiply stage: gain times Laplacian, and the square of the centre.
  logic signed [LapW-1:0]  lap;
  logic signed [DiffW-1:0] diff_d, diff_q;
  logic signed [SqW-1:0]   sq_d, sq_q;
  logic signed [GainW:0]   gain_s;

  assign gain_s = $signed({1'b0, gain_q});
  assign lap    = {{2{op_l[SampleW-1]}}, op_l} + {{2{op_r[SampleW-1]}}, op_r}
                - {op_c[SampleW-1], op_c, 1'b0};

  always_comb begin
    diff_d = lap * gain_s;
    sq_d   = op_c * op_c;
  end

  // Second multiply stage: the cube of the centre.
  logic signed [CubeW-1:0] cube_d, cube_q;
  always_comb cube_d = sq_q * op_c;

  // Sum in Q.30; the cube is floored to Q.30 and its dropped bits remembered
  // so that rounding can treat the exact value.
  logic signed [AccW-1:0] acc_d, acc_q;
  logic signed [AccW-1:0] diff_ext, cen_ext, cq_ext;
  logic                   rem_d, rem_q;

  always_comb begin
    diff_ext = {{(AccW-DiffW){diff_q[DiffW-1]}}, diff_q};
    cen_ext  = {{(AccW-SampleW-FracDrop){op_c[SampleW-1]}}, op_c, {FracDrop{1'b0}}};
    cq_ext   = {{(AccW-CubeW+CubeDrop){cube_q[CubeW-1]}}, cube_q[CubeW-1:CubeDrop]};
    acc_d    = diff_ext + cen_ext - cq_ext;
    rem_d    = |cube_q[CubeDrop-1:0];
  end

  // Round half up to Q.14, then saturate.
  logic signed [AccW-1:0]  bias, rnd_sum;
  logic signed [RndW-1:0]  rnd;
  logic signed [RateW-1:0] sat;

  always_comb begin
    bias    = {{(AccW-FracDrop){1'b0}}, 1'b1, {(FracDrop-1){1'b0}}};
    rnd_sum = acc_q + bias - {{(AccW-1){1'b0}}, rem_q};
    rnd     = rnd_sum[AccW-1:FracDrop];
    if (&rnd[RndW-1:RateW-1] || ~|rnd[RndW-1:RateW-1]) begin
      sat = rnd[RateW-1:0];
    end else if (rnd[RndW-1]) begin
      sat = {1'b1, {(RateW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(RateW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1_en) begin
      diff_q <= diff_d;
      sq_q   <= sq_d;
    end
    if (cmd_i.mul2_en) begin
      cube_q <= cube_d;
    end
    if (cmd_i.sum_en) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
    if (cmd_i.rnd_en) begin
      rate_o        <= sat;
      node_index_o  <= op_idx;
      run_last_o    <= (cmd_i.sel == JobFinal) || !has_final_q;
      vector_last_o <= (cmd_i.sel == JobFinal);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/allen_cahn_stencil_rhs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// allen_cahn_stencil_rhs
// Streaming right-hand side of the 1-D Allen-Cahn equation with Neumann ends.
// ----------------------------------------------------------------------------
// Grid values enter on the input channel (sample_i, compute_flag_i), one node
// per beat in node order. The rate of node i-1 is produced when node i
// arrives; the final node of a vector may produce a second rate for itself.
// Each result beat carries rate_o (Q17.14, saturated), node_index_o,
// run_last_o (last result of that input beat) and vector_last_o.
// The gain and node count are written through the cfg port; the user must
// write them only while idle, as the block itself does not enforce this.
// One input beat is taken, then the shared datapath runs its two multiply
// stages, the sum and the rounding for each result in turn. The centre-cube
// multiplies are chained and feed one adder in a single shared datapath.
// A result is held in the output register until taken; no new input is
// accepted meanwhile. Reset clears the delay line, the node counter and the
// configuration (gain 0, node count 2).
// ----------------------------------------------------------------------------
module allen_cahn_stencil_rhs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [acs_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [acs_pkg::CfgDataW-1:0]         cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [acs_pkg::SampleW-1:0]   sample_i,
  input  logic                                 compute_flag_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [acs_pkg::RateW-1:0]     rate_o,
  output logic [acs_pkg::IdxW-1:0]             node_index_o,
  output logic                                 run_last_o,
  output logic                                 vector_last_o
);
  import acs_pkg::*;

  acs_cmd_t    cmd;
  acs_status_t status;

  acs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  acs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_i       (sample_i),
    .compute_flag_i (compute_flag_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .rate_o         (rate_o),
    .node_index_o   (node_index_o),
    .run_last_o     (run_last_o),
    .vector_last_o  (vector_last_o)
  );

  // The block works on one beat at a time.
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // The final node's own rate always closes its input beat.
  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vector_last_o |-> run_last_o)
    else $error("final-node result not marked as last of its beat");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken in consecutive cycles");

  // A second result is still owed, so no new input may be taken.
  a_second_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_last_o |=> !in_ready_o)
    else $error("input accepted before the second result");

endmodule
`default_nettype wire
